// ----- src/m3inv_pkg.sv -----
package m3inv_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int NumElem   = 9;
  // signed cofactor: product of two elements, one bit of growth
  localparam int CofWidth  = 2 * DataWidth + 1;
  // signed determinant: element times cofactor, two bits of growth
  localparam int DetWidth  = DataWidth + CofWidth + 2;
  localparam int DetMagW   = DetWidth - 1;
  // numerator magnitude after the scale by 2^(2F)
  localparam int NumMagW   = CofWidth - 1 + 2 * FracBits;
  // quotient bits kept; anything above saturates
  localparam int QuoW      = DataWidth + 1;
  localparam int DivSteps  = QuoW + 1;

  typedef logic signed [DataWidth-1:0] elem_t;
  typedef logic signed [CofWidth-1:0]  cof_t;
  typedef logic signed [DetWidth-1:0]  det_t;
  typedef logic [DetMagW-1:0]          dmag_t;
  typedef logic [NumMagW-1:0]          nmag_t;

  typedef struct packed {
    logic [DataWidth-1:0] code;
    logic                 sat;
  } lane_res_t;
endpackage

// ----- src/m3inv_lane.sv -----
// Input register, then one restoring divide step per pipeline stage:
// |n| * 2^(2F) / |det|, rounded and saturated. The numerator bits above
// the divide window seed the remainder and flag quotients that cannot fit.
module m3inv_lane (
  input  logic                    clk,
  input  m3inv_pkg::cof_t         num,
  input  m3inv_pkg::dmag_t        dmag,
  input  logic                    dneg,
  output m3inv_pkg::lane_res_t    res
);
  import m3inv_pkg::*;

  localparam int RemW = DetMagW + 1;
  localparam int S = DivSteps;

  logic [RemW-1:0]   rem  [S+1];
  logic [S-1:0]      quo  [S+1];
  nmag_t             nrem [S+1];
  dmag_t             dv   [S+1];
  logic              neg  [S+1];
  logic              ovf  [S+1];

  nmag_t             nmag0;
  dmag_t             dmag0;
  logic              neg0;
  logic [NumMagW-1:0] hi_part;

  // Hold the scaled numerator magnitude ahead of the divide steps.
  always_ff @(posedge clk) begin
    nmag0 <= (num[CofWidth-1] ? NumMagW'(-num) : NumMagW'(num)) << (2 * FracBits);
    dmag0 <= dmag;
    neg0  <= num[CofWidth-1] ^ dneg;
  end

  // Numerator bits above the divide window; quotient overflows if that
  // part alone is at least det, otherwise it starts the remainder.
  assign hi_part = nmag0 >> (S - 1);

  assign rem[0]  = RemW'(hi_part);
  assign quo[0]  = '0;
  assign nrem[0] = nmag0;
  assign dv[0]   = dmag0;
  assign neg[0]  = neg0;
  assign ovf[0]  = (hi_part >= NumMagW'(dmag0));

  for (genvar k = 0; k < S; k++) begin : g_step
    logic [RemW-1:0] trial;
    logic            bitin;
    logic            ge;
    // after the scale, low bits for step k come from nmag0 bit S-1-k - 1
    // (the last step works on a zero bit appended for rounding)
    assign bitin = (k < S - 1) ? nrem[k][S - 2 - k] : 1'b0;
    assign trial = {rem[k][RemW-2:0], bitin};
    assign ge    = (trial >= RemW'(dv[k]));
    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? trial - RemW'(dv[k]) : trial;
      quo[k+1]  <= {quo[k][S-2:0], ge};
      nrem[k+1] <= nrem[k];
      dv[k+1]   <= dv[k];
      neg[k+1]  <= neg[k];
      ovf[k+1]  <= ovf[k];
    end
  end

  // quo[S] = 2*q_exact_window + halfbit; rounded q = (quo+1)>>1
  logic [S-1:0] qr;
  localparam logic [S-1:0] Half = S'(1) << (DataWidth - 1);
  assign qr = (quo[S] >> 1) + S'(quo[S][0]);

  always_ff @(posedge clk) begin
    if (neg[S]) begin
      if (ovf[S] || qr > Half) begin
        res.code <= {1'b1, {(DataWidth-1){1'b0}}};
        res.sat  <= 1'b1;
      end else begin
        res.code <= DataWidth'(-qr);
        res.sat  <= 1'b0;
      end
    end else begin
      if (ovf[S] || qr > Half - S'(1)) begin
        res.code <= {1'b0, {(DataWidth-1){1'b1}}};
        res.sat  <= 1'b1;
      end else begin
        res.code <= DataWidth'(qr);
        res.sat  <= 1'b0;
      end
    end
  end
endmodule

// ----- src/m3inv_cof.sv -----
// Cofactors and determinant: six registered stages.
module m3inv_cof (
  input  logic                    clk,
  input  m3inv_pkg::elem_t        a [9],
  output m3inv_pkg::cof_t         cof [9],
  output m3inv_pkg::dmag_t        dmag,
  output logic                    dneg,
  output logic                    dzero
);
  import m3inv_pkg::*;

  localparam int PW = 2 * DataWidth;
  logic signed [PW-1:0] p [18];
  elem_t ac [3];

  // product pairs: x*y - z*w for each cofactor, by matrix position
  function automatic int idx(input int k, input int s);
    int tb [36];
    tb = '{4,8,7,5,  6,5,3,8,  3,7,6,4,  7,2,1,8,  0,8,6,2,
           6,1,0,7,  1,5,4,2,  3,2,0,5,  0,4,3,1};
    return tb[4*k+s];
  endfunction

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++) begin
      p[2*k]   <= PW'(a[idx(k,0)]) * PW'(a[idx(k,1)]);
      p[2*k+1] <= PW'(a[idx(k,2)]) * PW'(a[idx(k,3)]);
    end
    ac[0] <= a[0];
    ac[1] <= a[3];
    ac[2] <= a[6];
  end

  cof_t c [9];
  elem_t ac2 [3];
  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++)
      c[k] <= CofWidth'(p[2*k]) - CofWidth'(p[2*k+1]);
    ac2 <= ac;
  end

  // cof order: 00,10,20,01,11,21,02,12,22 ; det uses 00,01,02
  // Split each element times cofactor into a low and a high 32 x 33 product.
  cof_t pl [3];
  cof_t ph [3];
  cof_t c3 [9];
  cof_t c4 [9];
  cof_t c5 [9];
  det_t t [3];
  det_t det;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      pl[j] <= CofWidth'(ac2[j]) * CofWidth'($signed({1'b0, c[3*j][DataWidth-1:0]}));
      ph[j] <= CofWidth'(ac2[j]) * CofWidth'($signed(c[3*j][CofWidth-1:DataWidth]));
    end
    c3 <= '{c[0], c[3], c[6], c[1], c[4], c[7], c[2], c[5], c[8]};
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++)
      t[j] <= (DetWidth'(ph[j]) <<< DataWidth) + DetWidth'(pl[j]);
    c4 <= c3;
  end

  always_ff @(posedge clk) begin
    det <= t[0] + t[1] + t[2];
    c5  <= c4;
  end

  always_ff @(posedge clk) begin
    dneg  <= det[DetWidth-1];
    dmag  <= det[DetWidth-1] ? DetMagW'(-det) : DetMagW'(det);
    dzero <= (det == '0);
    cof   <= c5;
  end
endmodule

// ----- src/matrix3_inverse_core.sv -----
// From the start transfer to done: six cofactor and determinant stages,
// a lane input register, DivSteps (34) divide steps, the lane output
// register and the merge register.
// Throughput: one matrix per cycle; busy is always low.
// Nine divider lanes run side by side, one per inverse element.
// Reset clears the valid pipeline; results strobe on done and cannot stall.
module matrix3_inverse_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  m3inv_pkg::elem_t a00, a01, a02, a10, a11, a12, a20, a21, a22,
  output logic done,
  output m3inv_pkg::elem_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22,
  output logic singular,
  output logic saturated
);
  import m3inv_pkg::*;

  localparam int CofLat  = 6;
  localparam int LaneLat = DivSteps + 2;
  localparam int Lat     = CofLat + LaneLat + 1;

  elem_t a [9];
  cof_t cof [9];
  dmag_t dmag;
  logic dneg, dzero;
  lane_res_t res [9];
  logic [Lat-1:0] vpipe;
  logic [LaneLat-1:0] zpipe;

  assign busy = 1'b0;
  assign a = '{a00, a01, a02, a10, a11, a12, a20, a21, a22};

  m3inv_cof u_cof (.clk, .a, .cof, .dmag, .dneg, .dzero);

  // a zero dmag is replaced by one so the lanes still divide; merge stage masks their junk
  for (genvar k = 0; k < 9; k++) begin : g_lane
    m3inv_lane u_lane (.clk, .num(cof[k]),
                       .dmag(dzero ? DetMagW'(1) : dmag), .dneg, .res(res[k]));
  end

  // Advance the transfer marker alongside the data; carry the singular
  // flag past the lanes so it meets their results.
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else vpipe <= {vpipe[Lat-2:0], start};
    zpipe <= {zpipe[LaneLat-2:0], dzero};
  end

  // Merge: zero out a singular result and gather the clip flags.
  logic z;
  logic anysat;
  elem_t o [9];

  assign z = zpipe[LaneLat-1];

  always_comb begin
    anysat = 1'b0;
    for (int k = 0; k < 9; k++)
      anysat = anysat | res[k].sat;
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 9; k++)
      o[k] <= z ? '0 : elem_t'(res[k].code);
    singular  <= z;
    saturated <= z ? 1'b0 : anysat;
  end

  assign done = vpipe[Lat-1];
  assign {inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22} =
    {o[0], o[1], o[2], o[3], o[4], o[5], o[6], o[7], o[8]};
endmodule

// ----- tb/tb.sv -----
module tb;
  import m3inv_pkg::*;

  // one inverse result as the block presents it
  typedef struct {
    logic [DataWidth-1:0] e[NumElem];
    logic                 singular;
    logic                 saturated;
  } inv_res_t;

  // Matrix inverse predictor plus the queue of inverses still owed.
  class inverse_board;
    inv_res_t owed[$];
    int       errors;

    function new();
      errors = 0;
    endfunction

    // Round-to-nearest (ties away), saturating n * 2^(2F) / d.
    function logic [DataWidth-1:0] scaled_quot(
      input logic signed [255:0] n, input logic signed [255:0] d, inout bit sat);
      logic [255:0] nm, dm, q, r;
      bit           neg;
      logic [255:0] half;
      nm   = n[255] ? -n : n;
      dm   = d[255] ? -d : d;
      neg  = n[255] ^ d[255];
      nm   = nm << (2 * FracBits);
      q    = nm / dm;
      r    = nm % dm;
      if ((r << 1) >= dm) q = q + 1;
      half = 256'd1 << (DataWidth - 1);
      if (neg) begin
        if (q > half) begin
          sat = 1;
          return half[DataWidth-1:0];
        end
        return DataWidth'(-q);
      end
      if (q > half - 1) begin
        sat = 1;
        return half[DataWidth-1:0] - 1;
      end
      return q[DataWidth-1:0];
    endfunction

    // Note an accepted matrix: compute its adjugate, determinant and inverse.
    function void note_matrix(input elem_t m[NumElem]);
      logic signed [255:0] a[3][3], c[3][3], det;
      inv_res_t            r;
      bit                  sat;
      sat = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          a[i][j] = m[i * 3 + j];
      c[0][0] = a[1][1] * a[2][2] - a[2][1] * a[1][2];
      c[1][0] = a[2][0] * a[1][2] - a[1][0] * a[2][2];
      c[2][0] = a[1][0] * a[2][1] - a[2][0] * a[1][1];
      c[0][1] = a[2][1] * a[0][2] - a[0][1] * a[2][2];
      c[1][1] = a[0][0] * a[2][2] - a[2][0] * a[0][2];
      c[2][1] = a[2][0] * a[0][1] - a[0][0] * a[2][1];
      c[0][2] = a[0][1] * a[1][2] - a[1][1] * a[0][2];
      c[1][2] = a[1][0] * a[0][2] - a[0][0] * a[1][2];
      c[2][2] = a[0][0] * a[1][1] - a[1][0] * a[0][1];
      det = a[0][0] * c[0][0] + a[1][0] * c[0][1] + a[2][0] * c[0][2];
      if (det == 0) begin
        foreach (r.e[k]) r.e[k] = '0;
        r.singular  = 1;
        r.saturated = 0;
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++)
            r.e[i * 3 + j] = scaled_quot(c[i][j], det, sat);
        r.singular  = 0;
        r.saturated = sat;
      end
      owed.push_back(r);
    endfunction

    // Compare one strobed inverse with the oldest one owed.
    function void check_inverse(input inv_res_t got);
      inv_res_t x;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, nothing owed", $time);
        errors++;
        return;
      end
      x = owed.pop_front();
      foreach (x.e[k])
        if (got.e[k] !== x.e[k]) begin
          $display("%0t: inv%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                   x.e[k], got.e[k]);
          errors++;
        end
      if (got.singular !== x.singular) begin
        $display("%0t: singular expected %b actual %b", $time, x.singular,
                 got.singular);
        errors++;
      end
      if (got.saturated !== x.saturated) begin
        $display("%0t: saturated expected %b actual %b", $time, x.saturated,
                 got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic  clk = 0;
  logic  rst = 1;
  logic  start = 0;
  logic  busy, done, singular, saturated;
  elem_t a00 = 0, a01 = 0, a02 = 0, a10 = 0, a11 = 0, a12 = 0, a20 = 0, a21 = 0, a22 = 0;
  elem_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;

  inverse_board board = new();

  always #10 clk = ~clk;

  matrix3_inverse_core dut (.*);

  // Results cannot be held off: sample every strobed transfer at the edge.
  always @(posedge clk) begin
    if (!rst && done) begin
      inv_res_t got;
      got.e = '{inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22};
      got.singular  = singular;
      got.saturated = saturated;
      board.check_inverse(got);
    end
  end

  // Short gaps mostly, now and then a long one, sometimes a run with none.
  // Drop start only when the gap really spends a cycle.
  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 9)) inside
      [0:3]:   n = 0;
      9:       n = $urandom_range(10, 60);
      default: n = $urandom_range(1, 3);
    endcase
    if (n > 0) begin
      start <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Present one matrix and hold it until the transfer happens.
  task automatic send_matrix(input elem_t m[NumElem]);
    start <= 1;
    {a00, a01, a02, a10, a11, a12, a20, a21, a22} <=
      {m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8]};
    do @(posedge clk); while (busy);
    board.note_matrix(m);
  endtask

  // Element drawn from a mix: full range, small Q16.16 values, extremes.
  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0:       return elem_t'($urandom);
      1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2:       return 0;
      3:       return $signed($urandom_range(0, 8)) - 4;
      4:       return ($signed($urandom_range(0, 4)) - 2) <<< FracBits;
      default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    endcase
  endfunction

  task automatic send_and_gap(input elem_t m[NumElem]);
    send_matrix(m);
    idle_gap();
  endtask

  localparam elem_t ONE = 1 <<< FracBits;

  initial begin
    elem_t m[NumElem];
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Identity, zero matrix, scaled diagonal, two singular matrices with dependent rows.
    m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};                        send_and_gap(m);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                              send_and_gap(m);
    m = '{2 * ONE, 0, 0, 0, -4 * ONE, 0, 0, 0, ONE / 2};           send_and_gap(m);
    m = '{ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE, 1, 1, 1}; send_and_gap(m);
    m = '{ONE, ONE, 0, ONE, ONE, 0, 0, 0, ONE};                    send_and_gap(m);
    // Tiny diagonal: inverse saturates high and low.
    m = '{1, 0, 0, 0, 1, 0, 0, 0, 1};                              send_and_gap(m);
    m = '{-1, 0, 0, 0, 1, 0, 0, 0, -1};                            send_and_gap(m);
    // Extremes of every field.
    foreach (m[k]) m[k] = 32'sh7fffffff;                           send_and_gap(m);
    foreach (m[k]) m[k] = 32'sh80000000;                           send_and_gap(m);
    m = '{32'sh80000000, 0, 0, 0, 32'sh7fffffff, 0, 0, 0, -1};      send_and_gap(m);
    m = '{32'sh7fffffff, 32'sh80000000, 1, -1, 32'sh7fffffff, 0,
          0, 32'sh80000000, 32'sh7fffffff};                         send_and_gap(m);
    // Small raw diagonal 3, -3 and 2: the thirds round and the half saturates high.
    m = '{3, 0, 0, 0, -3, 0, 0, 0, 2};                             send_and_gap(m);
    // Permutation with sign, exact inverse.
    m = '{0, ONE, 0, 0, 0, -ONE, ONE, 0, 0};                       send_and_gap(m);

    // Back-to-back bursts with mixed gaps.
    for (int n = 0; n < 1300; n++) begin
      foreach (m[k]) m[k] = rand_elem();
      if ($urandom_range(0, 19) == 0) begin
        // force a duplicated row so the determinant is zero
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end
      send_matrix(m);
      if ($urandom_range(0, 2) == 0)
        idle_gap();
    end
    start <= 0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #10000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule
